### sv/piecewise_linear_table_lookup_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise-linear table lookup
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_LOOKUP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PLTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PLTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pltl_pkg.sv
// ----------------------------------------------------------------------------
// pltl_pkg
// Shared constants, types and helpers of the piecewise-linear table lookup.
// ----------------------------------------------------------------------------
package pltl_pkg;

    // Table geometry and data widths
    localparam int MAX_POINTS  = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int DATA_W      = 16;
    localparam int NUM_W       = DATA_W + 1;
    localparam int DIFF_W      = DATA_W + 2;
    localparam int ROW_W       = 2 * DATA_W;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int WORD_IDX_W  = IDX_W + 1;
    localparam int CNT_W       = 5;

    // Configuration port
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_Y_FIRST     = 2'd1;
    localparam logic [1:0] REG_SIGNED_MODE = 2'd2;

    // Input word kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_ANS,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] point_count;
        logic             y_first;
        logic             signed_mode;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic wr;          // store one table word
        logic load_key;    // capture lookup key
        logic rd_first;    // read pair 0, restart walk
        logic walk_step;   // move to next pair
        logic take_y1;     // answer is y of previous pair
        logic take_y2;     // answer is y of current pair
        logic capture;     // latch deltas for interpolation
        logic mul;         // form product, seed divider
        logic div_step;    // one quotient bit
        logic ans_div;     // answer is y1 +/- quotient
        logic publish;     // move answer to output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;         // key <= x of current pair
        logic first;       // current pair is pair 0
        logic last;        // current pair is last in use
        logic degen;       // no interpolation step possible
        logic div_last;    // final divider step
    } status_t;

    // Raw word to number, sign extended in signed mode
    function automatic num_t to_num(input logic [DATA_W-1:0] raw, input logic sgn);
        to_num = {sgn & raw[DATA_W-1], raw};
    endfunction

endpackage

### sv/pltl_ctrl.sv
// ----------------------------------------------------------------------------
// pltl_ctrl
// Sequencer: accepts words, steps the table walk, divider and output slot.
// ----------------------------------------------------------------------------
`include "piecewise_linear_table_lookup_assert.svh"

module pltl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    output logic               out_valid,
    input  logic               out_ready,
    input  pltl_pkg::status_t  status,
    output pltl_pkg::cmd_t     cmd
);

    pltl_pkg::state_t state_reg;
    pltl_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             slot_free;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pltl_pkg::ST_IDLE:
            begin
                if (accept && kind == pltl_pkg::KIND_LOOKUP)
                    state_next = pltl_pkg::ST_FETCH;
            end
            pltl_pkg::ST_FETCH:
                state_next = pltl_pkg::ST_WALK;
            pltl_pkg::ST_WALK:
            begin
                if (status.hit)
                begin
                    if (status.first || status.degen)
                        state_next = pltl_pkg::ST_PUBLISH;
                    else
                        state_next = pltl_pkg::ST_MUL;
                end
                else if (status.last)
                    state_next = pltl_pkg::ST_PUBLISH;
            end
            pltl_pkg::ST_MUL:
                state_next = pltl_pkg::ST_DIV;
            pltl_pkg::ST_DIV:
            begin
                if (status.div_last)
                    state_next = pltl_pkg::ST_ANS;
            end
            pltl_pkg::ST_ANS:
                state_next = pltl_pkg::ST_PUBLISH;
            pltl_pkg::ST_PUBLISH:
            begin
                if (slot_free)
                    state_next = pltl_pkg::ST_IDLE;
            end
            default:
                state_next = pltl_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            pltl_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.wr       = accept && kind == pltl_pkg::KIND_LOAD;
                cmd.load_key = accept && kind == pltl_pkg::KIND_LOOKUP;
            end
            pltl_pkg::ST_FETCH:
                cmd.rd_first = 1'b1;
            pltl_pkg::ST_WALK:
            begin
                if (status.hit)
                begin
                    cmd.take_y2 = status.first;
                    cmd.take_y1 = !status.first && status.degen;
                    cmd.capture = !status.first && !status.degen;
                end
                else if (status.last)
                    cmd.take_y2 = 1'b1;
                else
                    cmd.walk_step = 1'b1;
            end
            pltl_pkg::ST_MUL:
                cmd.mul = 1'b1;
            pltl_pkg::ST_DIV:
                cmd.div_step = 1'b1;
            pltl_pkg::ST_ANS:
                cmd.ans_div = 1'b1;
            pltl_pkg::ST_PUBLISH:
                cmd.publish = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pltl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PLTL_ASSERT_NOW(a_publish_free, cmd.publish, !out_valid_reg || out_ready, "publish over held word")
    `PLTL_ASSERT_NEXT(a_lookup_starts, accept && kind == pltl_pkg::KIND_LOOKUP, state_reg == pltl_pkg::ST_FETCH, "lookup did not start walk")
    `PLTL_ASSERT_NEXT(a_div_ends, state_reg == pltl_pkg::ST_DIV && status.div_last, state_reg == pltl_pkg::ST_ANS, "divider overran")

endmodule

### sv/pltl_dpath.sv
// ----------------------------------------------------------------------------
// pltl_dpath
// Breakpoint memory, walk registers, multiplier, restoring divider, output.
// ----------------------------------------------------------------------------
`include "piecewise_linear_table_lookup_assert.svh"

module pltl_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pltl_pkg::cfg_t                      cfg,
    input  pltl_pkg::cmd_t                      cmd,
    output pltl_pkg::status_t                   status,
    input  logic [pltl_pkg::WORD_IDX_W-1:0]     word_index,
    input  logic [pltl_pkg::DATA_W-1:0]         table_word,
    input  logic [pltl_pkg::DATA_W-1:0]         key,
    output logic [pltl_pkg::DATA_W-1:0]         value
);

    localparam int DW = pltl_pkg::DATA_W;
    localparam int IW = pltl_pkg::IDX_W;

    // One row per pair: low half is word 2n, high half word 2n+1
    logic [pltl_pkg::ROW_W-1:0] mem [pltl_pkg::MAX_POINTS];
    logic [pltl_pkg::ROW_W-1:0] rdata_reg;
    logic [IW-1:0]              rd_addr;

    logic [IW-1:0]                  pair_idx_reg;
    logic [IW-1:0]                  last_idx;
    logic [pltl_pkg::CNT_W-1:0]     pc_m1;
    pltl_pkg::num_t                 key_reg;
    pltl_pkg::num_t                 x1_reg;
    pltl_pkg::num_t                 y1_reg;
    pltl_pkg::num_t                 x2;
    pltl_pkg::num_t                 y2;
    pltl_pkg::diff_t                dx_w;
    pltl_pkg::diff_t                dk_w;
    pltl_pkg::diff_t                dy_w;
    pltl_pkg::diff_t                mdy_w;
    logic [DW-1:0]                  dx_reg;
    logic [DW-1:0]                  dk_reg;
    logic [DW-1:0]                  mdy_reg;
    logic                           neg_reg;
    logic [pltl_pkg::PROD_W-1:0]    prod_w;
    logic [DW-1:0]                  rem_reg;
    logic [DW-1:0]                  qsh_reg;
    logic [pltl_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [DW:0]                    trial;
    logic [DW:0]                    trial_sub;
    logic                           trial_ge;
    logic [DW-1:0]                  ans_reg;
    logic [DW-1:0]                  value_reg;

    assign value = value_reg;

    // Pairs in use, clamped to the table
    assign pc_m1 = cfg.point_count - pltl_pkg::CNT_W'(1);
    always_comb
    begin
        if (cfg.point_count == '0)
            last_idx = '0;
        else if (cfg.point_count >= pltl_pkg::CNT_W'(pltl_pkg::MAX_POINTS))
            last_idx = IW'(pltl_pkg::MAX_POINTS - 1);
        else
            last_idx = pc_m1[IW-1:0];
    end

    // Memory write and registered read
    assign rd_addr = cmd.rd_first ? '0 : pair_idx_reg + IW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            if (word_index[0])
                mem[word_index[IW:1]][pltl_pkg::ROW_W-1:DW] <= table_word;
            else
                mem[word_index[IW:1]][DW-1:0] <= table_word;
        end
        if (cmd.rd_first || cmd.walk_step)
            rdata_reg <= mem[rd_addr];
    end

    // Current pair and deltas against the previous one
    always_comb
    begin
        if (cfg.y_first)
        begin
            y2 = pltl_pkg::to_num(rdata_reg[DW-1:0], cfg.signed_mode);
            x2 = pltl_pkg::to_num(rdata_reg[pltl_pkg::ROW_W-1:DW], cfg.signed_mode);
        end
        else
        begin
            x2 = pltl_pkg::to_num(rdata_reg[DW-1:0], cfg.signed_mode);
            y2 = pltl_pkg::to_num(rdata_reg[pltl_pkg::ROW_W-1:DW], cfg.signed_mode);
        end
    end

    assign dx_w  = {x2[DW], x2} - {x1_reg[DW], x1_reg};
    assign dk_w  = {key_reg[DW], key_reg} - {x1_reg[DW], x1_reg};
    assign dy_w  = {y2[DW], y2} - {y1_reg[DW], y1_reg};
    assign mdy_w = dy_w[pltl_pkg::DIFF_W-1] ? -dy_w : dy_w;

    // Status
    assign status.hit      = key_reg <= x2;
    assign status.first    = pair_idx_reg == '0;
    assign status.last     = pair_idx_reg == last_idx;
    assign status.degen    = dx_w[pltl_pkg::DIFF_W-1] || dx_w == '0 ||
                             dk_w[pltl_pkg::DIFF_W-1] || dk_w == '0;
    assign status.div_last = div_cnt_reg == pltl_pkg::DIV_CNT_W'(DW - 1);

    // Multiplier and divider step
    assign prod_w    = pltl_pkg::PROD_W'(mdy_reg) * pltl_pkg::PROD_W'(dk_reg);
    assign trial     = {rem_reg, qsh_reg[DW-1]};
    assign trial_ge  = trial >= {1'b0, dx_reg};
    assign trial_sub = trial - {1'b0, dx_reg};

    // Walk, arithmetic and answer registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
            key_reg <= pltl_pkg::to_num(key, cfg.signed_mode);
        if (cmd.rd_first)
            pair_idx_reg <= '0;
        if (cmd.walk_step)
        begin
            pair_idx_reg <= pair_idx_reg + IW'(1);
            x1_reg       <= x2;
            y1_reg       <= y2;
        end
        if (cmd.capture)
        begin
            dx_reg  <= dx_w[DW-1:0];
            dk_reg  <= dk_w[DW-1:0];
            mdy_reg <= mdy_w[DW-1:0];
            neg_reg <= dy_w[pltl_pkg::DIFF_W-1];
        end
        if (cmd.mul)
        begin
            rem_reg     <= prod_w[pltl_pkg::PROD_W-1:DW];
            qsh_reg     <= prod_w[DW-1:0];
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            qsh_reg     <= {qsh_reg[DW-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + pltl_pkg::DIV_CNT_W'(1);
        end
        if (cmd.take_y1)
            ans_reg <= y1_reg[DW-1:0];
        if (cmd.take_y2)
            ans_reg <= y2[DW-1:0];
        if (cmd.ans_div)
            ans_reg <= neg_reg ? y1_reg[DW-1:0] - qsh_reg : y1_reg[DW-1:0] + qsh_reg;
        if (cmd.publish)
            value_reg <= ans_reg;
    end

    `PLTL_ASSERT_NOW(a_rem_below_divisor, cmd.div_step, rem_reg < dx_reg, "divider remainder out of range")
    `PLTL_ASSERT_NOW(a_walk_in_range, cmd.walk_step, pair_idx_reg != last_idx, "walk stepped past last pair")
    `PLTL_ASSERT_NOW(a_step_positive, cmd.capture, !status.degen, "capture on flat step")

endmodule

### sv/piecewise_linear_table_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup
// Breakpoint table with linear interpolation between ascending x points.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) either load one raw table word (kind 0,
// pair n at word_index 2n and 2n+1) or look up a key (kind 1). Loads give no
// output word; lookups give one word on value (out_valid/out_ready).
// Registers on the APB port: point_count at 0x0, y_first at 0x4,
// signed_mode at 0x8; write them only while idle.
// A lookup walks k pairs (1..16), one pair per cycle from the breakpoint
// memory, and answers from the walk when the key clamps to an end point or
// lands exactly on a step edge. Otherwise it interpolates: a multiply, a
// restoring divide by the x step and a final add or subtract on y.
// One lookup is in flight at a time; in_ready is high only while idle, so
// the next word is taken only once a lookup has published its answer.
// A finished word sits in the output register; the next lookup runs while
// it waits and holds its answer until out_ready frees the register.
// Reset clears the sequencer, the output valid and the registers
// (point_count 1, others 0); table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [pltl_pkg::WORD_IDX_W-1:0]     word_index,
    input  logic [pltl_pkg::DATA_W-1:0]         table_word,
    input  logic [pltl_pkg::DATA_W-1:0]         key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pltl_pkg::DATA_W-1:0]         value,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pltl_pkg::PADDR_W-1:0]        paddr,
    input  logic [pltl_pkg::PDATA_W-1:0]        pwdata,
    output logic [pltl_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    pltl_pkg::cfg_t    cfg_reg;
    pltl_pkg::cmd_t    cmd;
    pltl_pkg::status_t status;
    logic              cfg_wr;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.point_count <= pltl_pkg::CNT_W'(1);
            cfg_reg.y_first     <= 1'b0;
            cfg_reg.signed_mode <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                pltl_pkg::REG_POINT_COUNT:
                    cfg_reg.point_count <= pwdata[pltl_pkg::CNT_W-1:0];
                pltl_pkg::REG_Y_FIRST:
                    cfg_reg.y_first <= pwdata[0];
                pltl_pkg::REG_SIGNED_MODE:
                    cfg_reg.signed_mode <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_sel)
            pltl_pkg::REG_POINT_COUNT:
                prdata = pltl_pkg::PDATA_W'(cfg_reg.point_count);
            pltl_pkg::REG_Y_FIRST:
                prdata = pltl_pkg::PDATA_W'(cfg_reg.y_first);
            pltl_pkg::REG_SIGNED_MODE:
                prdata = pltl_pkg::PDATA_W'(cfg_reg.signed_mode);
            default:
                prdata = '0;
        endcase
    end

    pltl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pltl_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .word_index (word_index),
        .table_word (table_word),
        .key        (key),
        .value      (value)
    );

endmodule

### sim/tb_piecewise_linear_table_lookup.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_lookup
// ----------------------------------------------------------------------------
// Self-checking bench for the piecewise-linear table lookup. Table loads and
// key lookups go in on the valid/ready input channel. The APB port sets the
// pair count, the pair layout and signed mode between phases. A behavioral
// interpolator tracks the table and the registers and queues the expected
// word for every accepted lookup. A checker compares each output word
// against the oldest queued value. Directed tests cover end clamps, signed
// falling slopes, pair count limits, irregular tables and a long output stall.
// Random phases then load mostly ascending tables and probe keys on, around
// and between breakpoints, with random idling on both channels and a full pause.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS    = pltl_pkg::MAX_POINTS;
    localparam int WORD_IDX_W    = pltl_pkg::WORD_IDX_W;
    localparam int DATA_W        = pltl_pkg::DATA_W;
    localparam int CNT_W         = pltl_pkg::CNT_W;
    localparam int PADDR_W       = pltl_pkg::PADDR_W;
    localparam int PDATA_W       = pltl_pkg::PDATA_W;

    localparam int TABLE_WORDS   = 2 * MAX_POINTS;
    localparam int LOOKUP_CYCLES = 40;      // above the worst-case lookup
    localparam int TARGET_ITEMS  = 1900;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 800000;

    // DUT connections
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   kind;
    logic [WORD_IDX_W-1:0]  word_index;
    logic [DATA_W-1:0]      table_word;
    logic [DATA_W-1:0]      key;
    logic                   out_valid;
    logic                   out_ready;
    logic [DATA_W-1:0]      value;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // Shadow of the table and registers
    logic [DATA_W-1:0]      table_words [TABLE_WORDS];
    logic [CNT_W-1:0]       cfg_points;
    logic                   cfg_y_first;
    logic                   cfg_signed;

    // Expected interpolated words, oldest first
    logic [DATA_W-1:0]      expected_values [$];

    // Ascending breakpoint x of the current table, in unsigned order
    int                     ordered_x [MAX_POINTS];
    int                     pairs_in_use;

    int                     idle_pct = 33;
    int                     hold_request = 0;
    int                     hold_left = 0;
    int                     mismatches = 0;
    int                     items_sent = 0;
    int                     cycle_count = 0;

    piecewise_linear_table_lookup DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .word_index (word_index),
        .table_word (table_word),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: random stalls, or a long hold when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request != 0)
        begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare every accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        logic [DATA_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_values.size() == 0)
            begin
                $error("value: unexpected word, expected none, actual 0x%04h", value);
                mismatches++;
            end
            else
            begin
                want = expected_values.pop_front();
                if (value !== want)
                begin
                    $error("value mismatch: expected 0x%04h, actual 0x%04h", want, value);
                    mismatches++;
                end
            end
        end
    end

    // Raw table or key bits as a number under the current mode
    function automatic longint as_number(input logic [DATA_W-1:0] raw);
        if (cfg_signed && raw[DATA_W-1])
            return longint'(raw) - (longint'(1) << DATA_W);
        return longint'(raw);
    endfunction

    // Walk the pairs in use and interpolate y for one key
    function automatic logic [DATA_W-1:0] interpolate(input logic [DATA_W-1:0] key_bits);
        longint k;
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint dx;
        longint dy;
        longint dk;
        longint q;
        longint res;
        int     n;
        k  = as_number(key_bits);
        x1 = 0;
        y1 = 0;
        n  = cfg_points;
        if (n == 0)
            n = 1;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        for (int i = 0; i < n; i++)
        begin
            x2 = as_number(cfg_y_first ? table_words[2*i+1] : table_words[2*i]);
            y2 = as_number(cfg_y_first ? table_words[2*i] : table_words[2*i+1]);
            if (k <= x2)
            begin
                if (i == 0)
                    return y2[DATA_W-1:0];
                dx = x2 - x1;
                dy = y2 - y1;
                dk = k - x1;
                if (dx <= 0 || dk <= 0)
                    return y1[DATA_W-1:0];
                q = ((dy < 0 ? -dy : dy) * dk) / dx;
                res = (dy < 0) ? y1 - q : y1 + q;
                return res[DATA_W-1:0];
            end
            x1 = x2;
            y1 = y2;
        end
        return y1[DATA_W-1:0];
    endfunction

    // One input word; prediction happens at the accepting edge
    task automatic send_word(input logic k, input logic [WORD_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] key_bits);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        word_index <= idx;
        table_word <= w;
        key        <= key_bits;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == pltl_pkg::KIND_LOAD)
            table_words[idx] = w;
        else
            expected_values.push_back(interpolate(key_bits));
        items_sent++;
    endtask

    task automatic load_word(input int idx, input logic [DATA_W-1:0] w);
        send_word(pltl_pkg::KIND_LOAD, WORD_IDX_W'(idx), w, DATA_W'($urandom_range(65535)));
    endtask

    task automatic look_up(input logic [DATA_W-1:0] key_bits);
        send_word(pltl_pkg::KIND_LOOKUP, WORD_IDX_W'($urandom_range(TABLE_WORDS - 1)),
                  DATA_W'($urandom_range(65535)), key_bits);
    endtask

    // Stop sending, wait for all results, then let the block go idle
    task automatic settle_block();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (expected_values.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LOOKUP_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle
    task automatic write_reg(input logic [1:0] reg_id, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (reg_id)
            pltl_pkg::REG_POINT_COUNT: cfg_points  = data[CNT_W-1:0];
            pltl_pkg::REG_Y_FIRST:     cfg_y_first = data[0];
            pltl_pkg::REG_SIGNED_MODE: cfg_signed  = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int points, input logic yf, input logic sgn);
        write_reg(pltl_pkg::REG_POINT_COUNT, PDATA_W'(points));
        write_reg(pltl_pkg::REG_Y_FIRST, PDATA_W'(yf));
        write_reg(pltl_pkg::REG_SIGNED_MODE, PDATA_W'(sgn));
        pairs_in_use = (cfg_points == 0) ? 1 :
                       (cfg_points > MAX_POINTS) ? MAX_POINTS : int'(cfg_points);
    endtask

    // Store one (x, y) pair in the current layout
    task automatic load_pair(input int n, input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
        load_word(2*n, cfg_y_first ? y : x);
        load_word(2*n + 1, cfg_y_first ? x : y);
    endtask

    // Ascending table over the pairs in use; noisy tables get random x
    task automatic load_breakpoints(input logic noisy);
        int          step_max;
        int          step;
        logic [15:0] flip;
        flip = cfg_signed ? 16'h8000 : 16'h0000;
        step_max = (pairs_in_use <= 2) ? 30000 : 4000;
        ordered_x[0] = $urandom_range(3000);
        for (int i = 1; i < pairs_in_use; i++)
        begin
            step = ($urandom_range(99) < 5) ? 0 : $urandom_range(step_max, 1);
            ordered_x[i] = (ordered_x[i-1] + step > 65535) ? 65535 : ordered_x[i-1] + step;
        end
        for (int i = 0; i < pairs_in_use; i++)
            load_pair(i, noisy ? DATA_W'($urandom_range(65535)) : DATA_W'(ordered_x[i]) ^ flip,
                      DATA_W'($urandom_range(65535)));
    endtask

    // Keys on, next to and between breakpoints, plus extremes and noise
    function automatic logic [DATA_W-1:0] pick_key();
        int          r;
        int          i;
        int          u;
        logic [15:0] flip;
        flip = cfg_signed ? 16'h8000 : 16'h0000;
        r = $urandom_range(99);
        i = $urandom_range(pairs_in_use - 1);
        if (r < 15)
            return DATA_W'($urandom_range(65535));
        if (r < 23)
        begin
            case ($urandom_range(3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h7FFF;
                default: return 16'h8000;
            endcase
        end
        if (r < 45)
            u = ordered_x[i] + $urandom_range(2) - 1;
        else if (i == pairs_in_use - 1)
            u = ordered_x[i] + $urandom_range(300);
        else
            u = ordered_x[i] + $urandom_range(ordered_x[i+1] - ordered_x[i]);
        return DATA_W'(u) ^ flip;
    endfunction

    // Every table word written once so no lookup reads an unwritten entry
    task automatic test_table_init();
        for (int i = 0; i < TABLE_WORDS; i++)
            load_word(i, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : DATA_W'($urandom_range(65535)));
    endtask

    // Clamps below the first and above the last x, exact hits, unsigned
    task automatic test_end_clamps();
        settle_block();
        configure(2, 1'b0, 1'b0);
        load_pair(0, 16'h0010, 16'h1000);
        load_pair(1, 16'hFFF0, 16'hFFFF);
        look_up(16'h0000);
        look_up(16'h0010);
        look_up(16'h0011);
        look_up(16'h8000);
        look_up(16'hFFF0);
        look_up(16'hFFFF);
    endtask

    // Signed mode, y before x, a falling then rising segment
    task automatic test_signed_slopes();
        settle_block();
        configure(3, 1'b1, 1'b1);
        load_pair(0, 16'hFC18, 16'h7FFF);
        load_pair(1, 16'h0000, 16'h8000);
        load_pair(2, 16'h03E8, 16'h7FFF);
        look_up(16'h8000);
        look_up(16'hFE0C);
        look_up(16'hFFFF);
        look_up(16'h01F4);
        look_up(16'h7FFF);
    endtask

    // Pair count zero acts as one pair; counts above the table saturate
    task automatic test_point_count_limits();
        settle_block();
        configure(0, 1'b0, 1'b0);
        look_up(16'hFFFF);
        look_up(DATA_W'($urandom_range(65535)));
        settle_block();
        configure(31, 1'b0, 1'b1);
        look_up(16'h7FFF);
        look_up(DATA_W'($urandom_range(65535)));
    endtask

    // Descending and repeated x values
    task automatic test_irregular_tables();
        settle_block();
        configure(4, 1'b0, 1'b0);
        load_pair(0, 16'h0100, 16'h2000);
        load_pair(1, 16'h0050, 16'h4000);
        load_pair(2, 16'h0300, 16'h0100);
        load_pair(3, 16'h0300, 16'hF000);
        look_up(16'h0060);
        look_up(16'h0200);
        look_up(16'h0300);
        look_up(16'h0301);
    endtask

    // Output held off while lookups keep coming, so the input stalls
    task automatic test_result_backpressure();
        settle_block();
        configure(16, 1'b0, 1'b0);
        load_breakpoints(1'b0);
        hold_request = 1;
        idle_pct = 0;
        for (int i = 0; i < 12; i++)
            look_up(pick_key());
        idle_pct = 33;
    endtask

    // Random phases: new registers, new table, then lookups with some noise
    task automatic test_random_phases();
        int phase;
        int points;
        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            settle_block();
            case (phase)
                0:       points = 1;
                1:       points = 16;
                2:       points = 17;
                3:       points = 2;
                4:       points = 0;
                default: points = $urandom_range(31);
            endcase
            configure(points, 1'($urandom_range(1)), 1'($urandom_range(1)));
            idle_pct = (phase == 5) ? 0 : 33;
            load_breakpoints($urandom_range(99) < 10);
            for (int i = 0; i < 60; i++)
            begin
                // sender pause until the block has drained
                if (phase == 7 && i == 30)
                    settle_block();
                if ($urandom_range(99) < 4)
                    load_word($urandom_range(TABLE_WORDS - 1), DATA_W'($urandom_range(65535)));
                else
                    look_up(pick_key());
            end
            phase++;
        end
        idle_pct = 33;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = pltl_pkg::KIND_LOAD;
        word_index = '0;
        table_word = '0;
        key        = '0;
        out_ready  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_points   = 5'd1;
        cfg_y_first  = 1'b0;
        cfg_signed   = 1'b0;
        pairs_in_use = 1;
        for (int i = 0; i < TABLE_WORDS; i++)
            table_words[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_init();
        test_end_clamps();
        test_signed_slopes();
        test_point_count_limits();
        test_irregular_tables();
        test_result_backpressure();
        test_random_phases();

        settle_block();
        if (expected_values.size() != 0)
        begin
            $error("value: %0d expected words never arrived", expected_values.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
